// ===== rtl/edf_ready_queue_selector_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the EDF ready queue selector
// Same-cycle and next-cycle implication checks on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef EDF_READY_QUEUE_SELECTOR_ASSERT_SVH
`define EDF_READY_QUEUE_SELECTOR_ASSERT_SVH

`define EDFRQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define EDFRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/edfrq_pkg.sv =====
// ----------------------------------------------------------------------------
// edfrq_pkg
// Shared types, codes and helpers of the EDF ready queue selector.
// ----------------------------------------------------------------------------
package edfrq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned TASK_W          = 8;
  localparam int unsigned DEADLINE_W      = 17;
  localparam int unsigned ARRIVAL_W       = 16;
  localparam int unsigned KEY_W           = DEADLINE_W + ARRIVAL_W + TASK_W;

  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic {
    FUNC_ENQUEUE = 1'b0,
    FUNC_PICK    = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_SHIFT_SET,
    ST_SHIFT,
    ST_SHIFT_END,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic    enq_wr;
    logic    pend_load;
    status_t pend_status;
    logic    pend_pick;
    logic    ptr_clr;
    logic    ptr_shift;
    logic    rd_issue;
    logic    rd_shift;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic ptr_last;
    logic best_last;
    logic out_free;
  } stat_t;

  // Ordering key: effective deadline, then arrival, then id; smaller ranks first.
  function automatic key_t make_key(input logic [TASK_W-1:0] task_id,
                                    input logic signed [DEADLINE_W-1:0] deadline,
                                    input logic [ARRIVAL_W-1:0] arrival);
    logic [DEADLINE_W-1:0] eff;
    eff = deadline[DEADLINE_W-1] ? {1'b1, {(DEADLINE_W-1){1'b0}}}
                                 : {1'b0, deadline[DEADLINE_W-2:0]};
    return {eff, arrival, task_id};
  endfunction

endpackage

// ===== rtl/edfrq_ctrl.sv =====
// ----------------------------------------------------------------------------
// edfrq_ctrl
// Sequencer of the EDF ready queue selector: accept, scan, compact, respond.
// ----------------------------------------------------------------------------
module edfrq_ctrl
  import edfrq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  input  logic  func,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (func_t'(func) == FUNC_PICK && !stat.empty) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_RESULT;
          end
        end
      end
      ST_SCAN: begin
        if (stat.ptr_last) begin
          state_next = ST_SCAN_END;
        end
      end
      ST_SCAN_END:  state_next = ST_SHIFT_SET;
      ST_SHIFT_SET: state_next = stat.best_last ? ST_RESULT : ST_SHIFT;
      ST_SHIFT: begin
        if (stat.ptr_last) begin
          state_next = ST_SHIFT_END;
        end
      end
      ST_SHIFT_END: state_next = ST_RESULT;
      ST_RESULT: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = (state == ST_IDLE);
    cmd       = '0;
    cmd.pend_status = STATUS_DONE;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.pend_load = 1'b1;
          if (func_t'(func) == FUNC_ENQUEUE) begin
            cmd.enq_wr      = !stat.full;
            cmd.pend_status = stat.full ? STATUS_FULL : STATUS_DONE;
          end else if (stat.empty) begin
            cmd.pend_status = STATUS_EMPTY;
          end else begin
            cmd.pend_pick = 1'b1;
            cmd.ptr_clr   = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_issue = 1'b1;
      end
      ST_SHIFT_SET: begin
        cmd.ptr_shift = 1'b1;
      end
      ST_SHIFT: begin
        cmd.rd_issue = 1'b1;
        cmd.rd_shift = 1'b1;
      end
      ST_RESULT: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd.out_load = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/edfrq_dp.sv =====
// ----------------------------------------------------------------------------
// edfrq_dp
// Datapath: entry memory, fill count, scan pointer, best key and result register.
// ----------------------------------------------------------------------------
module edfrq_dp
  import edfrq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  output stat_t                        stat,
  input  logic [TASK_W-1:0]            task_id,
  input  logic signed [DEADLINE_W-1:0] deadline,
  input  logic [ARRIVAL_W-1:0]         arrival,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic [1:0]                   status,
  output logic [TASK_W-1:0]            chosen_id
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  key_t          mem [QUEUE_DEPTH];
  logic [CW-1:0] count;
  logic [CW-1:0] ptr;
  key_t          rd_data;
  logic          rd_vld;
  logic          rd_shift_q;
  logic [AW-1:0] rd_idx;
  key_t          best_key;
  logic [AW-1:0] best_idx;
  status_t       pend_status;
  logic          pend_pick;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  key_t          wr_data;
  logic [CW-1:0] last_pos;

  assign last_pos = count - CW'(1);
  assign wr_en    = cmd.enq_wr | (rd_vld & rd_shift_q);
  assign wr_addr  = cmd.enq_wr ? count[AW-1:0] : rd_idx - AW'(1);
  assign wr_data  = cmd.enq_wr ? make_key(task_id, deadline, arrival) : rd_data;

  always_comb begin
    stat.full      = (count == CW'(QUEUE_DEPTH));
    stat.empty     = (count == '0);
    stat.ptr_last  = (ptr == last_pos);
    stat.best_last = (CW'(best_idx) == last_pos);
    stat.out_free  = !rsp_valid || rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_issue) begin
      rd_data <= mem[ptr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_vld    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_issue;
      if (cmd.enq_wr) begin
        count <= count + CW'(1);
      end else if (cmd.out_load && pend_pick) begin
        count <= count - CW'(1);
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_shift_q <= cmd.rd_shift;
    rd_idx     <= ptr[AW-1:0];
    if (cmd.ptr_clr) begin
      ptr <= '0;
    end else if (cmd.ptr_shift) begin
      ptr <= CW'(best_idx) + CW'(1);
    end else if (cmd.rd_issue) begin
      ptr <= ptr + CW'(1);
    end
    if (rd_vld && !rd_shift_q && (rd_idx == '0 || rd_data < best_key)) begin
      best_key <= rd_data;
      best_idx <= rd_idx;
    end
    if (cmd.pend_load) begin
      pend_status <= cmd.pend_status;
      pend_pick   <= cmd.pend_pick;
    end
    if (cmd.out_load) begin
      status    <= pend_status;
      chosen_id <= pend_pick ? best_key[TASK_W-1:0] : '0;
    end
  end

endmodule

// ===== rtl/edf_ready_queue_selector.sv =====
// ----------------------------------------------------------------------------
// edf_ready_queue_selector
// Earliest-deadline-first ready queue with enqueue and pick transactions.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_ready) carries func, task_id, deadline and
// arrival; func selects enqueue or pick. Response channel (rsp_valid/rsp_ready)
// returns one status and chosen_id per request transaction, in order.
// An enqueue appends to the queue, or is dropped with status full.
// A pick scans the n stored entries one per cycle through the entry memory's
// single read port, then compacts the entries after the chosen one at one
// per cycle; an empty queue answers with status empty.
// One request is processed at a time; req_ready is high only while idle.
// A finished response is held in the output register while the receiver
// stalls; the next request is still accepted, and its response waits until
// the register drains.
// Reset empties the queue and clears rsp_valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module edf_ready_queue_selector
  import edfrq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic                         func,
  input  logic [TASK_W-1:0]            task_id,
  input  logic signed [DEADLINE_W-1:0] deadline,
  input  logic [ARRIVAL_W-1:0]         arrival,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic [1:0]                   status,
  output logic [TASK_W-1:0]            chosen_id
);

  cmd_t  cmd;
  stat_t stat;

  edfrq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .func      (func),
    .stat      (stat),
    .cmd       (cmd)
  );

  edfrq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .task_id   (task_id),
    .deadline  (deadline),
    .arrival   (arrival),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .chosen_id (chosen_id)
  );

endmodule

// ===== rtl/edfrq_checker.sv =====
// ----------------------------------------------------------------------------
// edfrq_checker
// Port-level checks of the EDF ready queue selector, bound to the top level.
// ----------------------------------------------------------------------------
`include "edf_ready_queue_selector_assert.svh"

module edfrq_checker
  import edfrq_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   req_valid,
  input logic                   req_ready,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input logic [1:0]             status,
  input logic [TASK_W-1:0]      chosen_id
);

  `EDFRQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(chosen_id), "response changed while stalled")
  `EDFRQ_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while busy")
  `EDFRQ_ASSERT_SAME(a_id_only_on_pick, rsp_valid && status != STATUS_DONE, chosen_id == '0, "nonzero id on failed transaction")
  `EDFRQ_ASSERT_SAME(a_reset_clears, $past(rst), !rsp_valid, "response valid after reset")

endmodule

bind edf_ready_queue_selector edfrq_checker u_chk (.*);
